FILE: hw/rtl/tdf_pkg.sv
// Shared types, constants and codes of the damping force evaluator.
`default_nettype none
package tdf_pkg;
  localparam int unsigned MaxTerms = 16;
  localparam int unsigned MaxExponent = 7;
  localparam int unsigned IdxW = $clog2(MaxTerms);
  localparam int unsigned CntW = $clog2(MaxTerms + 1);
  localparam int unsigned ExpW = 3;
  localparam int unsigned CoefW = 40;
  localparam int unsigned VelW = 24;
  localparam int unsigned AccW = 64;

  typedef enum logic [1:0] {
    ReqClear = 2'd0,
    ReqAppend = 2'd1,
    ReqEval = 2'd2,
    ReqNone = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StFull = 2'd1,
    StAxis = 2'd2,
    StSat = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FsmIdle,
    FsmRead,
    FsmLoad,
    FsmMul,
    FsmMulHi,
    FsmAccum,
    FsmDone
  } fsm_e;

  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic [ExpW-1:0] eu;
    logic [ExpW-1:0] ev;
    logic [ExpW-1:0] ew;
  } term_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // take in the request item
    logic clear_sums;  // clear sums on every accepted request
    logic rd_en;       // read term at index
    logic [1:0] axis;
    logic [IdxW-1:0] idx;
    logic load;        // load term from read data
    logic mul_lo;      // low half multiply of current step
    logic mul_hi;      // high half multiply and update magnitude
    logic accum;       // subtract term from axis sum
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic steps_done;  // no more multiply steps for this term
  } stat_t;

  function automatic logic [ExpW-1:0] clamp_exp(input logic [ExpW-1:0] e);
    logic [ExpW-1:0] r;
    r = e;
    if (32'(e) > MaxExponent) r = ExpW'(MaxExponent);
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/tdf_ctrl.sv
// Controller sequencing requests, term reads and multiply steps.
`default_nettype none
module tdf_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [1:0] term_axis_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [1:0] status_o,
  input  wire logic sat_i,
  input  wire tdf_pkg::stat_t stat_i,
  output tdf_pkg::cmd_t cmd_o,
  output logic wr_en_o,
  output logic [1:0] wr_axis_o,
  output logic [tdf_pkg::IdxW-1:0] wr_idx_o,
  output logic is_eval_o
);
  tdf_pkg::fsm_e state_q, state_d;
  logic [tdf_pkg::CntW-1:0] cnt_q [3];
  logic [tdf_pkg::CntW-1:0] idx_q, idx_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] status_q, status_d;
  logic is_eval_q, is_eval_d;
  logic accept;
  logic last_term;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == tdf_pkg::FsmIdle);
  assign out_valid_o = (state_q == tdf_pkg::FsmDone);
  assign status_o = (is_eval_q && sat_i) ? tdf_pkg::StSat : status_q;
  assign is_eval_o = is_eval_q;
  assign last_term = (idx_q + 1'b1) >= cnt_q[axis_q];

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    axis_d = axis_q;
    status_d = status_q;
    is_eval_d = is_eval_q;
    case (state_q)
      tdf_pkg::FsmIdle: begin
        if (accept) begin
          status_d = tdf_pkg::StOk;
          is_eval_d = 1'b0;
          state_d = tdf_pkg::FsmDone;
          if (req_type_i == tdf_pkg::ReqAppend) begin
            if (term_axis_i == 2'd3) status_d = tdf_pkg::StAxis;
            else if (cnt_q[term_axis_i] >= tdf_pkg::CntW'(tdf_pkg::MaxTerms))
              status_d = tdf_pkg::StFull;
          end else if (req_type_i == tdf_pkg::ReqEval) begin
            is_eval_d = 1'b1;
            axis_d = 2'd0;
            idx_d = '0;
            state_d = tdf_pkg::FsmRead;
          end
        end
      end
      tdf_pkg::FsmRead: begin
        if (idx_q >= cnt_q[axis_q]) begin
          if (axis_q == 2'd2) state_d = tdf_pkg::FsmDone;
          else begin
            axis_d = axis_q + 2'd1;
            idx_d = '0;
          end
        end else state_d = tdf_pkg::FsmLoad;
      end
      tdf_pkg::FsmLoad: state_d = tdf_pkg::FsmMul;
      tdf_pkg::FsmMul: begin
        if (stat_i.steps_done) state_d = tdf_pkg::FsmAccum;
        else state_d = tdf_pkg::FsmMulHi;
      end
      tdf_pkg::FsmMulHi: state_d = tdf_pkg::FsmMul;
      tdf_pkg::FsmAccum: begin
        state_d = tdf_pkg::FsmRead;
        if (last_term) begin
          if (axis_q == 2'd2) state_d = tdf_pkg::FsmDone;
          else begin
            axis_d = axis_q + 2'd1;
            idx_d = '0;
          end
        end else idx_d = idx_q + 1'b1;
      end
      tdf_pkg::FsmDone: if (out_ready_i) state_d = tdf_pkg::FsmIdle;
      default: state_d = tdf_pkg::FsmIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    cmd_o.idx = idx_q[tdf_pkg::IdxW-1:0];
    cmd_o.capture = (state_q == tdf_pkg::FsmIdle) && accept;
    cmd_o.clear_sums = cmd_o.capture;
    cmd_o.rd_en = (state_q == tdf_pkg::FsmRead);
    cmd_o.load = (state_q == tdf_pkg::FsmLoad);
    cmd_o.mul_lo = (state_q == tdf_pkg::FsmMul) && !stat_i.steps_done;
    cmd_o.mul_hi = (state_q == tdf_pkg::FsmMulHi);
    cmd_o.accum = (state_q == tdf_pkg::FsmAccum);
    wr_en_o = accept && (req_type_i == tdf_pkg::ReqAppend) && (term_axis_i != 2'd3)
              && (cnt_q[term_axis_i] < tdf_pkg::CntW'(tdf_pkg::MaxTerms));
    wr_axis_o = term_axis_i;
    wr_idx_o = cnt_q[term_axis_i][tdf_pkg::IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdf_pkg::FsmIdle;
      idx_q <= '0;
      axis_q <= '0;
      status_q <= '0;
      is_eval_q <= 1'b0;
      for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      axis_q <= axis_d;
      status_q <= status_d;
      is_eval_q <= is_eval_d;
      if (accept && req_type_i == tdf_pkg::ReqClear) begin
        for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
      end else if (wr_en_o) begin
        cnt_q[term_axis_i] <= cnt_q[term_axis_i] + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/tdf_datapath.sv
// Term memories, shared 32x24 multiplier and saturating axis accumulators.
`default_nettype none
module tdf_datapath (
  input  wire logic clk_i,
  input  wire tdf_pkg::cmd_t cmd_i,
  output tdf_pkg::stat_t stat_o,
  input  wire logic wr_en_i,
  input  wire logic [1:0] wr_axis_i,
  input  wire logic [tdf_pkg::IdxW-1:0] wr_idx_i,
  input  wire logic [tdf_pkg::CoefW-1:0] coefficient_i,
  input  wire logic [tdf_pkg::ExpW-1:0] exp_u_i,
  input  wire logic [tdf_pkg::ExpW-1:0] exp_v_i,
  input  wire logic [tdf_pkg::ExpW-1:0] exp_w_i,
  input  wire logic [tdf_pkg::VelW-1:0] vel_x_i,
  input  wire logic [tdf_pkg::VelW-1:0] vel_y_i,
  input  wire logic [tdf_pkg::VelW-1:0] yaw_rate_i,
  input  wire logic is_eval_i,
  output logic [63:0] force_x_o,
  output logic [63:0] force_y_o,
  output logic [63:0] moment_z_o,
  output logic sat_o
);
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosMax = 64'h7FFF_FFFF_FFFF_FFFF;

  tdf_pkg::term_t mem_s [tdf_pkg::MaxTerms];
  tdf_pkg::term_t mem_y [tdf_pkg::MaxTerms];
  tdf_pkg::term_t mem_w [tdf_pkg::MaxTerms];
  tdf_pkg::term_t rd_s_q, rd_y_q, rd_w_q, rd_term;
  tdf_pkg::term_t wr_term;

  logic [tdf_pkg::VelW-1:0] vmag_q [3];
  logic [2:0] vneg_q;
  logic [63:0] sum_q [3];
  logic sat_q;
  logic [1:0] rd_axis_q;

  logic [63:0] mag_q;
  logic neg_q;
  logic [1:0] vsel_q;
  logic [2:0] left_q;
  // Remaining exponents held for the term being worked.
  logic [2:0] ev_q, ew_q;
  logic [55:0] lo_q;
  logic [31:0] mul_a;
  logic [55:0] prod;
  logic [23:0] vm;
  logic [1:0] vm_sel;
  logic vflip;
  logic [63:0] limit;
  logic [63:0] r;
  logic [63:0] term_val, diff;
  logic [2:0] e_u, e_v, e_w;
  logic [1:0] vsel_d;
  logic [2:0] left_d;
  logic [1:0] fl_s;

  assign wr_term = '{coef: coefficient_i, eu: tdf_pkg::clamp_exp(exp_u_i),
                     ev: tdf_pkg::clamp_exp(exp_v_i), ew: tdf_pkg::clamp_exp(exp_w_i)};

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_axis_i == 2'd0) mem_s[wr_idx_i] <= wr_term;
    if (wr_en_i && wr_axis_i == 2'd1) mem_y[wr_idx_i] <= wr_term;
    if (wr_en_i && wr_axis_i == 2'd2) mem_w[wr_idx_i] <= wr_term;
    if (cmd_i.rd_en) begin
      rd_s_q <= mem_s[cmd_i.idx];
      rd_y_q <= mem_y[cmd_i.idx];
      rd_w_q <= mem_w[cmd_i.idx];
      rd_axis_q <= cmd_i.axis;
    end
  end

  always_comb begin
    case (rd_axis_q)
      2'd0: rd_term = rd_s_q;
      2'd1: rd_term = rd_y_q;
      default: rd_term = rd_w_q;
    endcase
  end

  assign e_u = rd_term.eu;
  assign e_v = rd_term.ev;
  assign e_w = rd_term.ew;

  // Next velocity to work on, skipping zero exponents.
  always_comb begin
    vsel_d = vsel_q;
    left_d = left_q;
    if (left_q == 3'd0) begin
      if (vsel_q == 2'd0 && ev_q != 3'd0) begin
        vsel_d = 2'd1; left_d = ev_q;
      end else if ((vsel_q == 2'd0 || vsel_q == 2'd1) && ew_q != 3'd0) begin
        vsel_d = 2'd2; left_d = ew_q;
      end else vsel_d = 2'd3;
    end
  end
  assign fl_s = vsel_d;
  assign stat_o.steps_done = (fl_s == 2'd3);

  // Sign flip taken on when the walk moves on to the sway or yaw velocity.
  assign vflip = (vsel_d == 2'd1) ? (vneg_q[1] && (ev_q[1] ^ ev_q[0]))
                                  : (vneg_q[2] && (ew_q[1] ^ ew_q[0]));

  // The high half reuses the velocity chosen for the low half of the same step.
  assign vm_sel = cmd_i.mul_hi ? vsel_q : fl_s;
  assign vm = vmag_q[vm_sel == 2'd3 ? 2'd0 : vm_sel];
  assign mul_a = cmd_i.mul_hi ? mag_q[63:32] : mag_q[31:0];
  assign prod = 56'(mul_a) * 56'(vm);
  assign limit = neg_q ? SignBit : PosMax;
  assign r = {prod[43:0], 20'd0} + 64'(lo_q >> 12);

  assign term_val = neg_q ? (64'd0 - mag_q) : mag_q;
  assign diff = sum_q[rd_axis_q] - term_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vmag_q[0] <= vel_x_i[23] ? (24'd0 - vel_x_i) : vel_x_i;
      vmag_q[1] <= vel_y_i[23] ? (24'd0 - vel_y_i) : vel_y_i;
      vmag_q[2] <= yaw_rate_i[23] ? (24'd0 - yaw_rate_i) : yaw_rate_i;
      vneg_q <= {yaw_rate_i[23], vel_y_i[23], vel_x_i[23]};
    end
    if (cmd_i.clear_sums) begin
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      sat_q <= 1'b0;
    end
    if (cmd_i.load) begin
      mag_q <= rd_term.coef[39] ? (64'd0 - 64'($signed(rd_term.coef)))
                                : 64'(rd_term.coef);
      // The surge flip applies from the first multiply; later ones as they start.
      neg_q <= rd_term.coef[39]
             ^ (vneg_q[0] && e_u != 0 && e_u[1] ^ e_u[0] ? 1'b1 : 1'b0);
      vsel_q <= 2'd0;
      left_q <= e_u;
      ev_q <= e_v;
      ew_q <= e_w;
    end
    if (cmd_i.mul_lo) begin
      vsel_q <= vsel_d;
      left_q <= left_d - 3'd1;
      lo_q <= prod;
      if (vsel_d != vsel_q) neg_q <= neg_q ^ vflip;
    end
    if (cmd_i.mul_hi) begin
      if (prod >= 56'h800_0000_0000 || r > limit) begin
        mag_q <= limit;
        sat_q <= 1'b1;
      end else mag_q <= r;
    end
    if (cmd_i.accum) begin
      if (((sum_q[rd_axis_q] ^ term_val) & SignBit) != 0 &&
          ((diff ^ sum_q[rd_axis_q]) & SignBit) != 0) begin
        sum_q[rd_axis_q] <= sum_q[rd_axis_q][63] ? SignBit : PosMax;
        sat_q <= 1'b1;
      end else sum_q[rd_axis_q] <= diff;
    end
  end

  assign force_x_o = is_eval_i ? sum_q[0] : 64'd0;
  assign force_y_o = is_eval_i ? sum_q[1] : 64'd0;
  assign moment_z_o = is_eval_i ? sum_q[2] : 64'd0;
  assign sat_o = sat_q;
endmodule
`default_nettype wire

FILE: hw/rtl/taylor_damping_force_eval_unit.sv
// Top level of the Taylor-expansion damping force evaluator.
// Clear, append and unused requests give their result 1 cycle after acceptance.
// Evaluate walks each axis table in turn and, per term, runs every multiply (up to 21)
// as a low and a high half on the shared 32x24 multiplier.
// One item at a time; the next item is accepted the cycle after the result is taken.
// Reset clears the term counts; term memories hold whatever was last written.
`default_nettype none
module taylor_damping_force_eval_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // req_type[1:0], term_axis[3:2], coefficient[43:4], exp_u[46:44], exp_v[49:47],
  // exp_w[52:50], vel_x[76:53], vel_y[100:77], yaw_rate[124:101], zero fill
  input  wire logic [127:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // force_x[63:0], force_y[127:64], moment_z[191:128], status[193:192], zero fill
  output logic [199:0] m_axis_tdata_o
);
  tdf_pkg::cmd_t cmd;
  tdf_pkg::stat_t stat;
  logic wr_en, is_eval, sat;
  logic [1:0] wr_axis, status;
  logic [tdf_pkg::IdxW-1:0] wr_idx;
  logic [63:0] fx, fy, mz;

  tdf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .req_type_i(s_axis_tdata_i[1:0]), .term_axis_i(s_axis_tdata_i[3:2]),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .status_o(status), .sat_i(sat), .stat_i(stat), .cmd_o(cmd),
    .wr_en_o(wr_en), .wr_axis_o(wr_axis), .wr_idx_o(wr_idx), .is_eval_o(is_eval)
  );

  tdf_datapath u_dp (
    .clk_i, .cmd_i(cmd), .stat_o(stat),
    .wr_en_i(wr_en), .wr_axis_i(wr_axis), .wr_idx_i(wr_idx),
    .coefficient_i(s_axis_tdata_i[43:4]),
    .exp_u_i(s_axis_tdata_i[46:44]), .exp_v_i(s_axis_tdata_i[49:47]),
    .exp_w_i(s_axis_tdata_i[52:50]),
    .vel_x_i(s_axis_tdata_i[76:53]), .vel_y_i(s_axis_tdata_i[100:77]),
    .yaw_rate_i(s_axis_tdata_i[124:101]),
    .is_eval_i(is_eval),
    .force_x_o(fx), .force_y_o(fy), .moment_z_o(mz), .sat_o(sat)
  );

  assign m_axis_tdata_o = {6'd0, status, mz, fy, fx};
endmodule
`default_nettype wire
